>>> design/text_mode_console_writer_macros.svh
// Assertion macros for the text-mode console writer.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef TEXT_MODE_CONSOLE_WRITER_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define TMCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked on every rising clock edge outside reset.
`define TMCW_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

>>> design/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package tmcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  localparam logic [7:0] BLANK   = 8'h20;
  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  character;
    logic [3:0]  fore_colour;
    logic [3:0]  back_colour;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  cell_char;
    logic [7:0]  cell_style;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic latch;
    logic put;
    logic home;
    logic set_a;
    logic set_b;
    logic read;
    logic fill_we;
    logic fill_zero;
    logic cnt_fill;
    logic cnt_scroll;
    logic cnt_inc;
    logic sweep;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       need_scroll;
    logic       fill_last;
    logic       scroll_last;
    logic       out_free;
  } sts_t;

endpackage

>>> design/tmcw_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is supplied by the instantiating code, normally from tmcw_pkg.
`timescale 1ns / 1ps

interface tmcw_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

>>> design/tmcw_ctrl.sv
// Sequencing state machine of the text-mode console writer.
// Depends on tmcw_pkg for the command and status structs.
`timescale 1ns / 1ps

module tmcw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  tmcw_pkg::sts_t sts_i,
  output tmcw_pkg::ctl_t ctl_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SETB   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        ctl_o.fill_we   = 1'b1;
        ctl_o.fill_zero = 1'b1;
        ctl_o.cnt_inc   = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts_i.cmd)
          tmcw_pkg::CMD_PUT: begin
            ctl_o.put = 1'b1;
            if (sts_i.need_scroll) begin
              ctl_o.cnt_scroll = 1'b1;
              state_d          = S_SCROLL;
            end else begin
              state_d = S_RESP;
            end
          end
          tmcw_pkg::CMD_CLEAR: begin
            ctl_o.home     = 1'b1;
            ctl_o.cnt_fill = 1'b1;
            state_d        = S_FILL;
          end
          tmcw_pkg::CMD_SET: begin
            ctl_o.set_a = 1'b1;
            state_d     = S_SETB;
          end
          tmcw_pkg::CMD_READ: begin
            ctl_o.read = 1'b1;
            state_d    = S_RESP;
          end
        endcase
      end
      S_SETB: begin
        ctl_o.set_b = 1'b1;
        state_d     = S_RESP;
      end
      S_FILL: begin
        ctl_o.fill_we = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_RESP;
        end
      end
      S_SCROLL: begin
        ctl_o.sweep   = 1'b1;
        ctl_o.cnt_inc = 1'b1;
        if (sts_i.scroll_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.in_ready = 1'b1;
          if (in_valid_i) begin
            ctl_o.latch = 1'b1;
            state_d     = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

>>> design/tmcw_datapath.sv
// Datapath of the text-mode console writer: cell store, cursor, sweep counter
// and result register. Depends on tmcw_pkg; driven by tmcw_ctrl commands.
`timescale 1ns / 1ps

module tmcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmcw_pkg::ctl_t      ctl_i,
  output tmcw_pkg::sts_t      sts_o,
  input  tmcw_pkg::in_item_t  in_payload_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmcw_pkg::out_item_t out_payload_o
);

  localparam int EXTENT       = COLUMNS * ROWS;
  localparam int AW           = $clog2(EXTENT);
  localparam int AW1          = AW + 1;
  localparam int CW           = $clog2(EXTENT + COLUMNS);
  localparam int PW           = $clog2(255 * (COLUMNS + 1) + 1);
  localparam int RECIP_SHIFT  = 17;
  localparam int RECIP        = (2 ** RECIP_SHIFT + COLUMNS - 1) / COLUMNS;
  localparam int MW           = 8 + RECIP_SHIFT;

  // Latched item fields.
  logic [1:0]  cmd_q;
  logic [7:0]  char_q;
  logic [7:0]  style_q;
  logic [7:0]  col_q;
  logic [7:0]  row_q;
  logic [10:0] idx_q;

  // Cursor and the start of its row.
  logic [AW-1:0] cursor_q, base_q;

  // Sweep counter and the delayed write of the scroll copy.
  logic [CW-1:0] cnt_q;
  logic          pend_q;
  logic [AW-1:0] pend_addr_q;
  logic          pend_blank_q;

  // Set-cursor intermediate products.
  logic [MW-1:0] prod_q;
  logic [PW-1:0] rowmul_q;

  // Cell store.
  logic [15:0]   mem_q [EXTENT];
  logic [15:0]   rd_data_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic                out_valid_q;
  tmcw_pkg::out_item_t out_payload_q;

  logic          is_newline, idx_ok, in_top;
  logic [AW1-1:0] adv, row_end;
  logic [AW-1:0] scroll_raddr, scroll_waddr;
  logic [7:0]    quo;
  logic [PW-1:0] set_pos, set_base;

  assign is_newline = (char_q == tmcw_pkg::NEWLINE);
  assign idx_ok     = (32'(idx_q) < 32'(EXTENT));

  // Advance target: next cell, or the next row's start for a newline.
  assign row_end = AW1'(base_q) + AW1'(COLUMNS);
  assign adv     = is_newline ? row_end : (AW1'(cursor_q) + AW1'(1));

  // Scroll sweep runs the counter from COLUMNS to EXTENT + COLUMNS - 1. Below
  // EXTENT each cell moves up one row; from EXTENT on the bottom row is blanked.
  assign in_top       = (cnt_q < CW'(EXTENT));
  assign scroll_waddr = AW'(cnt_q - CW'(COLUMNS));
  assign scroll_raddr = in_top ? AW'(cnt_q) : scroll_waddr;

  // Column reduction by reciprocal: col / COLUMNS is exact for col below 256.
  assign quo      = prod_q[MW-1:RECIP_SHIFT];
  assign set_pos  = rowmul_q + PW'(col_q);
  assign set_base = rowmul_q + PW'(quo) * PW'(COLUMNS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= in_payload_i.command;
      char_q  <= in_payload_i.character;
      style_q <= {in_payload_i.back_colour, in_payload_i.fore_colour};
      col_q   <= in_payload_i.col;
      row_q   <= in_payload_i.row;
      idx_q   <= in_payload_i.cell_index;
    end
    if (ctl_i.set_a) begin
      prod_q   <= MW'(col_q) * MW'(RECIP);
      rowmul_q <= PW'(row_q) * PW'(COLUMNS);
    end
    pend_addr_q  <= scroll_waddr;
    pend_blank_q <= !in_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      base_q   <= '0;
    end else if (ctl_i.home || (ctl_i.put && (adv >= AW1'(EXTENT)))) begin
      cursor_q <= AW'(EXTENT - COLUMNS);
      base_q   <= AW'(EXTENT - COLUMNS);
    end else if (ctl_i.put) begin
      cursor_q <= AW'(adv);
      if (adv == row_end) begin
        base_q <= AW'(row_end);
      end
    end else if (ctl_i.set_b) begin
      if (set_pos >= PW'(EXTENT)) begin
        cursor_q <= AW'(EXTENT - 1);
        base_q   <= AW'(EXTENT - COLUMNS);
      end else begin
        cursor_q <= AW'(set_pos);
        base_q   <= AW'(set_base);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctl_i.sweep;
      if (ctl_i.cnt_fill) begin
        cnt_q <= '0;
      end else if (ctl_i.cnt_scroll) begin
        cnt_q <= CW'(COLUMNS);
      end else if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Single write port shared by the scroll copy, the fill sweep and printing.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_q);
    mem_wdata = '0;
    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_blank_q ? {rd_data_q[15:8], tmcw_pkg::BLANK} : rd_data_q;
    end else if (ctl_i.fill_we) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cnt_q);
      mem_wdata = ctl_i.fill_zero ? 16'h0000 : {style_q, tmcw_pkg::BLANK};
    end else if (ctl_i.put && !is_newline) begin
      mem_we    = 1'b1;
      mem_waddr = cursor_q;
      mem_wdata = {style_q, char_q};
    end
    mem_re    = ctl_i.sweep || (ctl_i.read && idx_ok);
    mem_raddr = ctl_i.sweep ? scroll_raddr : AW'(idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_payload_q.cursor_pos <= 11'(cursor_q);
      if ((cmd_q == tmcw_pkg::CMD_READ) && idx_ok) begin
        out_payload_q.cell_char  <= rd_data_q[7:0];
        out_payload_q.cell_style <= rd_data_q[15:8];
      end else begin
        out_payload_q.cell_char  <= '0;
        out_payload_q.cell_style <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_payload_q;

  assign sts_o.cmd         = cmd_q;
  assign sts_o.need_scroll = (adv >= AW1'(EXTENT));
  assign sts_o.fill_last   = (cnt_q == CW'(EXTENT - 1));
  assign sts_o.scroll_last = (cnt_q == CW'(EXTENT + COLUMNS - 1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

>>> design/text_mode_console_writer.sv
// Text-mode console writer. The controller works on one item at a time: a new
// transaction is taken only once the previous result has been loaded into the
// output register. Clear and a scrolling put sweep the store one cell a cycle,
// all COLUMNS*ROWS cells each, input held not ready. Reset is asynchronous;
// after it a clearing pass zeroes the store with the input held.
`timescale 1ns / 1ps
`include "text_mode_console_writer_macros.svh"

module text_mode_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic             clk_i,
  input logic             rst_ni,
  tmcw_stream_if.sink     in_i,
  tmcw_stream_if.source   out_o
);

  // The controller decides what happens each cycle; the datapath holds the
  // cell store, the cursor with its row start, and the result register. The
  // two talk only through the command and status structs below.
  tmcw_pkg::ctl_t ctl_s;
  tmcw_pkg::sts_t sts_s;

  // The controller takes a new transaction when idle, or in the same cycle in
  // which the previous result moves into the output register, so a waiting
  // result does not block the next item.
  tmcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts_s),
    .ctl_o      (ctl_s)
  );

  // Scrolling copies each cell one row up: the read is registered, so the
  // matching write lands in the following cycle and the sweep ends with one trailing
  // write. Printing, filling and that trailing write never share a cycle.
  tmcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl_s),
    .sts_o         (sts_s),
    .in_payload_i  (in_i.payload),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_payload_o (out_o.payload)
  );

  assign in_i.ready = ctl_s.in_ready;

  // No transaction may be taken while the store is being swept.
  `TMCW_ASSERT_IMPL(a_no_accept_in_sweep, in_i.valid && in_i.ready, !ctl_s.fill_we && !ctl_s.sweep, "transaction accepted during a sweep")
  // A result is only loaded when the output register is free.
  `TMCW_ASSERT_IMPL(a_load_when_free, ctl_s.out_load, sts_s.out_free, "result overwrote a waiting result")
  // At most one store operation is commanded in any cycle.
  `TMCW_ASSERT_ALWAYS(a_one_action, $onehot0({ctl_s.put, ctl_s.set_b, ctl_s.read, ctl_s.fill_we, ctl_s.sweep}), "conflicting datapath commands")

endmodule
